FILE: rtl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared types and fixed-point constants of the RTD resistance converter.
// ----------------------------------------------------------------------------
package rtd_pkg;

  // Aligned resistance, Q24 ohm, wide enough for any in-range value
  localparam int RW = 34;
  // Quotient bits produced by the divider before saturation
  localparam int QBITS = 33;

  localparam logic signed [63:0] COEF_A = 64'sd1678602068;
  localparam logic signed [63:0] COEF_B = -64'sd16255179905;
  localparam logic signed [22:0] COEF_C = -23'sd3767711;
  localparam logic signed [63:0] R100   = 64'sd100 <<< 24;
  localparam logic signed [47:0] X100   = 48'sd100 <<< 20;
  localparam logic signed [47:0] X300   = 48'sd300 <<< 20;
  localparam logic signed [35:0] X_MIN  = -(36'sd1 <<< 30);
  localparam logic signed [35:0] X_MAX  = (36'sd1 <<< 30) - 36'sd1;
  localparam logic signed [35:0] T_MIN  = -36'sd4194304;
  localparam logic signed [35:0] T_MAX  = 36'sd4194303;
  localparam logic [32:0]        STEP_LIM = 33'd1 << 32;

  // Range limits on the resistance, scaled by 100 and 1000
  localparam logic [63:0] LO_LIM = 64'd1852 << 24;
  localparam logic [63:0] HI_LIM = 64'd390481 << 24;

  localparam logic [5:0]  MAX_ITER_RST = 6'd50;
  localparam logic [11:0] TOL_RST      = 12'd4;

  // Register indexes on the configuration port
  localparam logic REG_MAX_ITER = 1'b0;
  localparam logic REG_TOL      = 1'b1;

  typedef struct packed {
    logic          oor;
    logic          quart;
    logic [RW-1:0] r;
  } job_t;

  typedef struct packed {
    logic signed [22:0] temp;
    logic               oor;
  } res_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_INIT,
    BS_INIT_WAIT,
    BS_MUL,
    BS_MUL_WAIT,
    BS_DIV,
    BS_DIV_WAIT,
    BS_ROUND,
    BS_EMIT
  } bstate_e;

  typedef enum logic [2:0] {
    OP_W,
    OP_I2,
    OP_I1,
    OP_F,
    OP_Z,
    OP_D2,
    OP_D
  } mop_e;

  function automatic logic signed [31:0] clamp_x(input logic signed [35:0] v);
    logic signed [35:0] c;
    c = v;
    if (v < X_MIN) c = X_MIN;
    if (v > X_MAX) c = X_MAX;
    return c[31:0];
  endfunction

endpackage

FILE: rtl/rtd_resistance_to_temperature.sv
// ----------------------------------------------------------------------------
// rtd_resistance_to_temperature
// PT100 resistance to temperature by Newton inversion of Callendar-Van Dusen.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive resistance_i and push; a word is taken at a
//   clock edge with push high and full low. Results come out of a queue:
//   temperature_o and out_of_range_o hold the oldest word while empty is low;
//   pop it with pop. Both sides hold up to two words, so the input keeps
//   accepting while a finished word waits.
//   An out-of-range word skips the Newton iteration. An in-range word runs
//   Newton steps, at most max_iterations of them. Each step is seven passes
//   through the shared multiplier and one pass through the radix-2 divider
//   (33 quotient bits); the divider dominates. Words are processed one at a
//   time in the back end.
//   Reset empties both queues and returns max_iterations to 50 and tolerance
//   to 4. If the receiver stalls, the result queue fills, the back end holds
//   its word, then the input queue fills and full rises.
//   Registers (APB, write only while idle): 0x0 max_iterations, 0x4 tolerance.
// ----------------------------------------------------------------------------
module rtd_resistance_to_temperature #(
  parameter int RES_FRAC_BITS  = 16,
  parameter int TEMP_FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [24:0]        resistance_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [22:0] temperature_o,
  output logic               out_of_range_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [5:0]    max_iter_q;
  logic [11:0]   tol_q;
  logic          cfg_wr;

  rtd_pkg::job_t job;
  logic          job_empty, job_pop;
  rtd_pkg::res_t res_in, res_out;
  logic          res_full, res_push;
  logic [$bits(rtd_pkg::res_t)-1:0] res_bits;

  // Configuration registers; index taken from the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= rtd_pkg::MAX_ITER_RST;
      tol_q      <= rtd_pkg::TOL_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        rtd_pkg::REG_MAX_ITER: max_iter_q <= pwdata[5:0];
        rtd_pkg::REG_TOL:      tol_q      <= pwdata[11:0];
        default:               tol_q      <= tol_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rtd_pkg::REG_MAX_ITER: prdata = 32'(max_iter_q);
      rtd_pkg::REG_TOL:      prdata = 32'(tol_q);
      default:               prdata = '0;
    endcase
  end

  // Front end: classify and queue
  rtd_front #(
    .RES_FRAC_BITS (RES_FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .resistance_i (resistance_i),
    .full_o       (full),
    .job_pop_i    (job_pop),
    .job_o        (job),
    .job_empty_o  (job_empty)
  );

  // Back end: iterate
  rtd_newton #(
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_newton (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .max_iter_i  (max_iter_q),
    .tol_i       (tol_q)
  );

  // Result queue decouples the receiver from the back end
  rtd_fifo #(
    .W     ($bits(rtd_pkg::res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_bits),
    .empty_o (empty)
  );

  assign res_out        = rtd_pkg::res_t'(res_bits);
  assign temperature_o  = res_out.temp;
  assign out_of_range_o = res_out.oor;

endmodule

FILE: rtl/rtd_fifo.sv
// ----------------------------------------------------------------------------
// rtd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rtd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/rtd_front.sv
// ----------------------------------------------------------------------------
// rtd_front
// Align the resistance, check its range, pick the curve and queue the job.
// ----------------------------------------------------------------------------
module rtd_front #(
  parameter int RES_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [24:0]        resistance_i,
  output logic               full_o,
  input  logic               job_pop_i,
  output rtd_pkg::job_t      job_o,
  output logic               job_empty_o
);

  localparam int RSHIFT = 24 - RES_FRAC_BITS;

  logic [63:0]   r64;
  rtd_pkg::job_t job_in;
  logic [$bits(rtd_pkg::job_t)-1:0] job_bits;

  always_comb begin
    r64          = 64'(resistance_i) << RSHIFT;
    job_in.oor   = (r64 * 64'd100 < rtd_pkg::LO_LIM) || (r64 * 64'd1000 > rtd_pkg::HI_LIM);
    job_in.quart = (r64 < 64'(rtd_pkg::R100));
    job_in.r     = r64[rtd_pkg::RW-1:0];
  end

  rtd_fifo #(
    .W     ($bits(rtd_pkg::job_t)),
    .DEPTH (2)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (job_in),
    .full_o  (full_o),
    .pop_i   (job_pop_i),
    .data_o  (job_bits),
    .empty_o (job_empty_o)
  );

  assign job_o = rtd_pkg::job_t'(job_bits);

endmodule

FILE: rtl/rtd_mul.sv
// ----------------------------------------------------------------------------
// rtd_mul
// Signed 32 x 48 multiplier, two partial products then a registered sum.
// ----------------------------------------------------------------------------
module rtd_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] a_i,
  input  logic signed [47:0] b_i,
  output logic               valid_o,
  output logic signed [63:0] p_o
);

  logic signed [56:0] lo_q;
  logic signed [55:0] hi_q;
  logic signed [79:0] sum;
  logic               v1_q, v2_q;

  assign sum = $signed({hi_q, 24'b0}) + 80'(lo_q);

  always_ff @(posedge clk_i) begin
    lo_q <= a_i * $signed({1'b0, b_i[23:0]});
    hi_q <= a_i * $signed(b_i[47:24]);
    p_o  <= sum[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;

endmodule

FILE: rtl/rtd_div.sv
// ----------------------------------------------------------------------------
// rtd_div
// Signed num * 2^28 / den, truncated, saturated to +-2^32; one bit a cycle.
// ----------------------------------------------------------------------------
module rtd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [39:0] num_i,
  input  logic        [39:0] den_i,
  output logic               done_o,
  output logic signed [33:0] quo_o
);

  localparam int QB = rtd_pkg::QBITS;

  logic              busy_q, done_q, neg_q;
  logic [5:0]        cnt_q;
  logic [39:0]       rem_q, den_q;
  logic [QB-1:0]     sh_q, q_q;
  logic [39:0]       mag;
  logic              ovf;
  logic [40:0]       trial;
  logic              qbit;
  logic [39:0]       rem_d;
  logic [QB-1:0]     q_d;
  logic [QB-1:0]     qm;

  always_comb begin
    mag   = num_i[39] ? 40'(-num_i) : 40'(num_i);
    ovf   = ({5'b0, mag} >= {den_i, 5'b0});
    trial = {1'b0, rem_q[38:0], sh_q[QB-1]} - {1'b0, den_q};
    qbit  = rem_q[39] || !trial[40];
    rem_d = qbit ? trial[39:0] : {rem_q[38:0], sh_q[QB-1]};
    q_d   = {q_q[QB-2:0], qbit};
    qm    = (q_d > QB'(rtd_pkg::STEP_LIM)) ? QB'(rtd_pkg::STEP_LIM) : q_d;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[39];
      den_q <= den_i;
      rem_q <= mag >> 5;
      sh_q  <= {mag[4:0], 28'b0};
      q_q   <= '0;
      if (ovf) begin
        quo_o <= num_i[39] ? -34'(rtd_pkg::STEP_LIM) : 34'(rtd_pkg::STEP_LIM);
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_q << 1;
      q_q   <= q_d;
      if (cnt_q == 6'(QB - 1)) begin
        quo_o <= neg_q ? -34'(qm) : 34'(qm);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !ovf;
        done_q <= ovf;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(QB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/rtd_newton.sv
// ----------------------------------------------------------------------------
// rtd_newton
// Back end: Newton iteration on the Callendar-Van Dusen curve.
// ----------------------------------------------------------------------------
module rtd_newton #(
  parameter int TEMP_FRAC_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_empty_i,
  input  rtd_pkg::job_t job_i,
  output logic          job_pop_o,
  input  logic          res_full_i,
  output rtd_pkg::res_t res_o,
  output logic          res_push_o,
  input  logic [5:0]    max_iter_i,
  input  logic [11:0]   tol_i
);

  localparam int TSHIFT = 20 - TEMP_FRAC_BITS;
  localparam logic signed [35:0] RND = (36'sd1 <<< TSHIFT) >>> 1;

  rtd_pkg::bstate_e   state_q, state_d;
  rtd_pkg::mop_e      op_q;
  logic signed [31:0] x_q;
  logic signed [47:0] t_q;
  logic signed [39:0] f_q, d_q;
  logic [rtd_pkg::RW-1:0] r_q;
  logic               quart_q;
  logic [5:0]         cnt_q;
  rtd_pkg::res_t      res_q;

  logic               mul_valid, mul_done;
  logic signed [31:0] mul_a;
  logic signed [47:0] mul_b;
  logic signed [63:0] p;
  logic               div_start, div_done;
  logic signed [39:0] div_num;
  logic        [39:0] div_den;
  logic signed [33:0] quo;

  logic signed [31:0] c_ext;
  logic signed [63:0] r_s;
  logic signed [63:0] d_full;
  logic        [33:0] mag;
  logic               stop;
  logic signed [35:0] t_full, t_sat;

  assign c_ext = quart_q ? 32'(rtd_pkg::COEF_C) : '0;
  assign r_s   = $signed({30'b0, r_q});

  // Multiplier operands for the current term
  always_comb begin
    mul_a = x_q;
    mul_b = t_q;
    case (op_q)
      rtd_pkg::OP_W:  mul_b = 48'(x_q) - rtd_pkg::X100;
      rtd_pkg::OP_I2: mul_a = c_ext;
      rtd_pkg::OP_I1: mul_b = t_q >>> 16;
      rtd_pkg::OP_F:  mul_b = t_q;
      rtd_pkg::OP_Z:  mul_b = (48'(x_q) <<< 2) - rtd_pkg::X300;
      rtd_pkg::OP_D2: mul_a = c_ext;
      rtd_pkg::OP_D:  mul_b = t_q >>> 16;
      default:        mul_b = t_q;
    endcase
  end

  always_comb begin
    d_full  = rtd_pkg::COEF_A + (p >>> 20);
    mag     = quo[33] ? 34'(-quo) : 34'(quo);
    stop    = (mag < (34'(tol_i) << TSHIFT)) || (7'(cnt_q) + 7'd1 == 7'(max_iter_i));
    t_full  = (36'(x_q) + RND) >>> TSHIFT;
    t_sat   = t_full;
    if (t_full < rtd_pkg::T_MIN) t_sat = rtd_pkg::T_MIN;
    if (t_full > rtd_pkg::T_MAX) t_sat = rtd_pkg::T_MAX;
    div_num = (state_q == rtd_pkg::BS_INIT) ? 40'(r_s - rtd_pkg::R100) : f_q;
    div_den = (state_q == rtd_pkg::BS_INIT) ? 40'(rtd_pkg::COEF_A) : d_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rtd_pkg::BS_IDLE: begin
        if (!job_empty_i) state_d = job_i.oor ? rtd_pkg::BS_EMIT : rtd_pkg::BS_INIT;
      end
      rtd_pkg::BS_INIT: state_d = rtd_pkg::BS_INIT_WAIT;
      rtd_pkg::BS_INIT_WAIT: begin
        if (div_done) state_d = (max_iter_i == '0) ? rtd_pkg::BS_ROUND : rtd_pkg::BS_MUL;
      end
      rtd_pkg::BS_MUL: state_d = rtd_pkg::BS_MUL_WAIT;
      rtd_pkg::BS_MUL_WAIT: begin
        if (mul_done) begin
          if (op_q != rtd_pkg::OP_D) state_d = rtd_pkg::BS_MUL;
          else if (d_full <= 0)      state_d = rtd_pkg::BS_ROUND;
          else                       state_d = rtd_pkg::BS_DIV;
        end
      end
      rtd_pkg::BS_DIV: state_d = rtd_pkg::BS_DIV_WAIT;
      rtd_pkg::BS_DIV_WAIT: begin
        if (div_done) state_d = stop ? rtd_pkg::BS_ROUND : rtd_pkg::BS_MUL;
      end
      rtd_pkg::BS_ROUND: state_d = rtd_pkg::BS_EMIT;
      rtd_pkg::BS_EMIT: begin
        if (!res_full_i) state_d = rtd_pkg::BS_IDLE;
      end
      default: state_d = rtd_pkg::BS_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    job_pop_o  = (state_q == rtd_pkg::BS_IDLE) && !job_empty_i;
    mul_valid  = (state_q == rtd_pkg::BS_MUL);
    div_start  = (state_q == rtd_pkg::BS_INIT) || (state_q == rtd_pkg::BS_DIV);
    res_push_o = (state_q == rtd_pkg::BS_EMIT) && !res_full_i;
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      rtd_pkg::BS_IDLE: begin
        r_q      <= job_i.r;
        quart_q  <= job_i.quart;
        res_q    <= '{temp: '0, oor: job_i.oor};
      end
      rtd_pkg::BS_INIT_WAIT: begin
        if (div_done) x_q <= rtd_pkg::clamp_x(36'(quo));
      end
      rtd_pkg::BS_MUL_WAIT: begin
        if (mul_done) begin
          case (op_q)
            rtd_pkg::OP_W:  t_q <= 48'(p >>> 20);
            rtd_pkg::OP_I2: t_q <= 48'(rtd_pkg::COEF_B + (p >>> 25));
            rtd_pkg::OP_I1: t_q <= 48'(rtd_pkg::COEF_A + (p >>> 20));
            rtd_pkg::OP_F:  f_q <= 40'(r_s - rtd_pkg::R100 - (p >>> 28));
            rtd_pkg::OP_Z:  t_q <= 48'(p >>> 24);
            rtd_pkg::OP_D2: t_q <= 48'((rtd_pkg::COEF_B <<< 1) + (p >>> 21));
            rtd_pkg::OP_D:  d_q <= 40'(d_full);
            default:        t_q <= t_q;
          endcase
        end
      end
      rtd_pkg::BS_DIV_WAIT: begin
        if (div_done) x_q <= rtd_pkg::clamp_x(36'(x_q) + 36'(quo));
      end
      rtd_pkg::BS_ROUND: begin
        res_q <= '{temp: t_sat[22:0], oor: 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtd_pkg::BS_IDLE;
      op_q    <= rtd_pkg::OP_W;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == rtd_pkg::BS_INIT_WAIT && div_done) begin
        cnt_q <= '0;
        op_q  <= rtd_pkg::OP_W;
      end
      if (state_q == rtd_pkg::BS_MUL_WAIT && mul_done) begin
        case (op_q)
          rtd_pkg::OP_W:  op_q <= rtd_pkg::OP_I2;
          rtd_pkg::OP_I2: op_q <= rtd_pkg::OP_I1;
          rtd_pkg::OP_I1: op_q <= rtd_pkg::OP_F;
          rtd_pkg::OP_F:  op_q <= rtd_pkg::OP_Z;
          rtd_pkg::OP_Z:  op_q <= rtd_pkg::OP_D2;
          rtd_pkg::OP_D2: op_q <= rtd_pkg::OP_D;
          default:        op_q <= rtd_pkg::OP_W;
        endcase
      end
      if (state_q == rtd_pkg::BS_DIV_WAIT && div_done) begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  rtd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .valid_o (mul_done),
    .p_o     (p)
  );

  rtd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

endmodule

FILE: rtl/rtd_checker.sv
// ----------------------------------------------------------------------------
// rtd_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module rtd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic [24:0]        resistance_i,
  input logic               empty,
  input logic               pop,
  input logic signed [22:0] temperature_o,
  input logic               out_of_range_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  // Out-of-range words carry a zero temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_of_range_o) |-> (temperature_o == 23'sd0))
    else $error("out-of-range word with nonzero temperature");

  // Both queues are empty and not full while in reset
  assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queue status wrong during reset");

  // A written limit reads back on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
      |-> (prdata == {26'b0, $past(pwdata[5:0])}))
    else $error("max_iterations readback mismatch");

  // A waiting result stays until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

endmodule

bind rtd_resistance_to_temperature rtd_checker u_rtd_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PT100 resistance to temperature converter.
// Drive resistance words through the input queue under several register
// settings, compute each expected temperature with a fixed-point Newton model
// of the Callendar-Van Dusen inversion, and compare every popped word field by
// field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic [2:0] ADDR_MAX_ITER = {rtd_pkg::REG_MAX_ITER, 2'b00};
  localparam logic [2:0] ADDR_TOL      = {rtd_pkg::REG_TOL, 2'b00};

  // Resistance codes at the edges of the valid band (18.52 and 390.481 ohm)
  localparam logic [24:0] RES_LO_OUT = 25'd1213726;
  localparam logic [24:0] RES_LO_IN  = 25'd1213727;
  localparam logic [24:0] RES_HI_IN  = 25'd25590562;
  localparam logic [24:0] RES_HI_OUT = 25'd25590563;
  localparam logic [24:0] RES_100    = 25'd6553600;

  typedef struct {
    logic signed [22:0] temp;
    logic               oor;
  } reading_t;

  typedef struct {
    logic [24:0] res;
    bit          typed;
    reading_t    want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [24:0]        resistance_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [22:0] temperature_o;
  logic               out_of_range_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  rtd_resistance_to_temperature dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Local copy of the registers, tracked alongside every write
  logic [5:0]  iter_limit = rtd_pkg::MAX_ITER_RST;
  logic [11:0] step_tol   = rtd_pkg::TOL_RST;

  reading_t pending_temps[$];
  int       error_count = 0;
  int       quiet_cycles = 0;
  bit       no_idle = 1'b0;
  int       rx_stall = 0;

  task automatic report(input string what);
    error_count++;
    $display("MISMATCH %s at %0t", what, $realtime);
  endtask

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Newton inversion in the block's fixed-point format: r is Q24 ohm, x Q20 degC
  function automatic reading_t predict_temp(input logic [24:0] rin);
    longint r, c, x, tol, w, i2, i1, f, z, d2, d, step, mag, t;
    reading_t o;
    r = longint'(rin) << 8;
    if (r * 100 < (longint'(1852) << 24) || r * 1000 > (longint'(390481) << 24)) begin
      o.temp = '0;
      o.oor  = 1'b1;
      return o;
    end
    // quartic term only below 100 ohm
    c   = (r < rtd_pkg::R100) ? longint'(rtd_pkg::COEF_C) : 0;
    x   = clip((r - rtd_pkg::R100) * 268435456 / rtd_pkg::COEF_A,
               rtd_pkg::X_MIN, rtd_pkg::X_MAX);
    tol = longint'(step_tol) << 8;
    for (int k = 0; k < iter_limit; k++) begin
      w  = (x * (x - (longint'(100) << 20))) >>> 20;
      i2 = rtd_pkg::COEF_B + ((c * w) >>> 25);
      i1 = rtd_pkg::COEF_A + ((x * (i2 >>> 16)) >>> 20);
      f  = r - rtd_pkg::R100 - ((x * i1) >>> 28);
      z  = (x * (4 * x - (longint'(300) << 20))) >>> 24;
      d2 = 2 * rtd_pkg::COEF_B + ((c * z) >>> 21);
      d  = rtd_pkg::COEF_A + ((x * (d2 >>> 16)) >>> 20);
      // flat or falling slope: keep the current iterate
      if (d <= 0) break;
      step = clip(f * 268435456 / d, -(longint'(1) << 32), longint'(1) << 32);
      x    = clip(x + step, rtd_pkg::X_MIN, rtd_pkg::X_MAX);
      mag  = (step < 0) ? -step : step;
      if (mag < tol) break;
    end
    // round half up to 12 fraction bits, then saturate to the port width
    t = clip((x + 128) >>> 8, rtd_pkg::T_MIN, rtd_pkg::T_MAX);
    o.temp = t[22:0];
    o.oor  = 1'b0;
    return o;
  endfunction

  // Hold push high until the word is taken; advance only on the handshake
  task automatic send_word(input logic [24:0] res, input bit typed, input reading_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    resistance_i <= res;
    do @(posedge clk_i); while (full);
    pending_temps.push_back(typed ? want : predict_temp(res));
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MAX_ITER) iter_limit = data[5:0];
    else step_tol = data[11:0];
  endtask

  // Drop push, drain every pending word, then let the back end settle
  task automatic drain();
    push <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Mostly in-band values, with some around 100 ohm, some outside the band
  // and some over the whole field so that every bit toggles
  function automatic logic [24:0] random_res();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 25'($urandom_range(RES_LO_IN, RES_HI_IN));
    if (sel < 75) return 25'($urandom_range(RES_100 - 40000, RES_100 + 40000));
    if (sel < 82) return 25'($urandom_range(RES_LO_OUT - 50, RES_LO_IN + 50));
    if (sel < 89) return 25'($urandom_range(RES_HI_IN - 50, RES_HI_OUT + 50));
    return 25'($urandom);
  endfunction

  // Result side: check the oldest word, then draw the next stall
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (pending_temps.size() == 0) begin
        report("unexpected word");
      end else begin
        if (temperature_o !== pending_temps[0].temp)
          report($sformatf("temperature got %0d want %0d",
                           temperature_o, pending_temps[0].temp));
        if (out_of_range_o !== pending_temps[0].oor)
          report($sformatf("out_of_range got %b want %b",
                           out_of_range_o, pending_temps[0].oor));
        void'(pending_temps.pop_front());
      end
      rx_stall = no_idle ? 0 : $urandom_range(0, 7);
    end
    if (rx_stall > 0) begin
      pop <= 1'b0;
      rx_stall--;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: end the run when neither side moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  stim_row_t directed[] = '{
    '{25'd0,        1'b1, '{23'sd0, 1'b1}},
    '{25'h1FFFFFF,  1'b1, '{23'sd0, 1'b1}},
    '{RES_LO_OUT,   1'b1, '{23'sd0, 1'b1}},
    '{RES_LO_IN,    1'b0, '{23'sd0, 1'b0}},
    '{RES_HI_IN,    1'b0, '{23'sd0, 1'b0}},
    '{RES_HI_OUT,   1'b1, '{23'sd0, 1'b1}},
    '{RES_100,      1'b1, '{23'sd0, 1'b0}},
    '{RES_100 - 1,  1'b0, '{23'sd0, 1'b0}},
    '{RES_100 + 1,  1'b0, '{23'sd0, 1'b0}},
    '{25'd3276800,  1'b0, '{23'sd0, 1'b0}},
    '{25'd9830400,  1'b0, '{23'sd0, 1'b0}},
    '{25'd16384000, 1'b0, '{23'sd0, 1'b0}},
    '{25'd22937600, 1'b0, '{23'sd0, 1'b0}},
    '{25'h0AAAAAA,  1'b0, '{23'sd0, 1'b0}},
    '{25'h1555555,  1'b0, '{23'sd0, 1'b0}}
  };

  // Register settings per phase: extremes of both fields included
  int phase_iter[] = '{50, 63, 1, 0, 7, 5, 63};
  int phase_tol[]  = '{4, 0, 4095, 0, 100, 1, 4095};
  int phase_len[]  = '{45, 20, 50, 40, 50, 50, 45};

  initial begin
    reading_t dummy;
    dummy = '{23'sd0, 1'b0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under reset values of the registers
    foreach (directed[i]) send_word(directed[i].res, directed[i].typed, directed[i].want);
    drain();

    foreach (phase_iter[p]) begin
      reg_write(ADDR_MAX_ITER, 32'(phase_iter[p]));
      reg_write(ADDR_TOL, 32'(phase_tol[p]));
      // every other phase runs back to back with no idling
      no_idle = (p % 2 == 1);
      // zero tolerance at the largest limit is slow: keep it short
      if (phase_tol[p] == 0 && phase_iter[p] == 63) begin
        for (int k = 0; k < phase_len[p]; k++) begin
          send_word(25'($urandom_range(RES_LO_IN, RES_HI_IN)), 1'b0, dummy);
        end
      end else begin
        for (int k = 0; k < phase_len[p]; k++) send_word(random_res(), 1'b0, dummy);
      end
      drain();
    end

    no_idle = 1'b0;
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && pending_temps.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
